@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property checked on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Antecedent this cycle implies consequent on the next edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/gsfe_pkg.sv @@
`default_nettype none

package gsfe_pkg;

    typedef enum logic [1:0] {
        MODE_WAIT,
        MODE_HEADER,
        MODE_GGA,
        MODE_RMC
    } t_mode;

    typedef enum logic [2:0] {
        KIND_TIME  = 3'd0,
        KIND_NS    = 3'd1,
        KIND_EW    = 3'd2,
        KIND_SAT   = 3'd3,
        KIND_SPEED = 3'd4
    } t_kind;

    // Raw characters of one completed field, chars[0] received first.
    typedef struct packed {
        t_kind            kind;
        logic [5:0][7:0]  chars;
    } t_cap;

    // Decoded field; speed still needs the knots to km/h scaling.
    typedef struct packed {
        t_kind        kind;
        logic [6:0]   hours;
        logic [6:0]   minutes;
        logic [6:0]   seconds;
        logic [14:0]  value;
        logic [13:0]  mant;
        logic [1:0]   scale;
    } t_dec;

    localparam logic [7:0]  CH_DOLLAR = 8'h24;
    localparam logic [39:0] HDR_GGA   = 40'h47_50_47_47_41;   // GPGGA
    localparam logic [39:0] HDR_RMC   = 40'h47_50_52_4D_43;   // GPRMC

    localparam logic [5:0] POS_MAX        = 6'd63;
    localparam logic [5:0] POS_HDR_LAST   = 6'd5;
    localparam logic [5:0] POS_TIME_FIRST = 6'd7;
    localparam logic [5:0] POS_TIME_LAST  = 6'd12;
    localparam logic [5:0] POS_NS         = 6'd28;
    localparam logic [5:0] POS_EW         = 6'd41;
    localparam logic [5:0] POS_SAT_FIRST  = 6'd45;
    localparam logic [5:0] POS_SAT_LAST   = 6'd46;
    localparam logic [5:0] POS_SPD_FIRST  = 6'd45;
    localparam logic [5:0] POS_SPD_LAST   = 6'd48;

    localparam logic [4:0] HOUR_OFFSET_RST = 5'd1;

    // km/h = floor(m * 463 / (250 * 10^scale)); reciprocals ceil(463 * 2^32 / divisor)
    // are exact for every 4-digit mantissa.
    localparam int         SPEED_SHIFT = 32;
    localparam logic [32:0] SPEED_RECIP [4] = '{
        33'd7954279433,
        33'd795427944,
        33'd79542795,
        33'd7954280
    };

endpackage

`default_nettype wire

@@ rtl/gsfe_parser.sv @@
`default_nettype none

`include "assert_macros.svh"

module gsfe_parser (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_accept,
    input  wire logic [7:0]     i_rx_byte,
    output logic                o_cap_valid,
    output gsfe_pkg::t_cap      o_cap
);

    logic [5:0]       r_pos;
    logic [5:0]       n_pos;
    logic [5:0]       w_pos_inc;
    gsfe_pkg::t_mode  r_mode;
    gsfe_pkg::t_mode  n_mode;
    logic [7:0]       r_hdr [4];
    logic [7:0]       r_time [6];
    logic [7:0]       r_sat;
    logic [7:0]       r_spd [3];
    logic             w_dollar;
    logic             w_live;
    logic             n_emit;
    gsfe_pkg::t_cap   n_cap;
    logic             r_cap_valid;
    gsfe_pkg::t_cap   r_cap;

    assign w_dollar  = (i_rx_byte == gsfe_pkg::CH_DOLLAR);
    assign w_live    = i_accept && !w_dollar;
    assign w_pos_inc = (r_pos == gsfe_pkg::POS_MAX) ? r_pos : r_pos + 6'd1;

    // next state
    always_comb begin
        n_pos  = r_pos;
        n_mode = r_mode;
        if (i_accept && w_dollar) begin
            n_pos  = '0;
            n_mode = gsfe_pkg::MODE_HEADER;
        end else if (w_live && r_mode != gsfe_pkg::MODE_WAIT) begin
            n_pos = w_pos_inc;
            if (r_mode == gsfe_pkg::MODE_HEADER && w_pos_inc == gsfe_pkg::POS_HDR_LAST) begin
                if ({r_hdr[0], r_hdr[1], r_hdr[2], r_hdr[3], i_rx_byte} == gsfe_pkg::HDR_GGA) begin
                    n_mode = gsfe_pkg::MODE_GGA;
                end else if ({r_hdr[0], r_hdr[1], r_hdr[2], r_hdr[3], i_rx_byte}
                             == gsfe_pkg::HDR_RMC) begin
                    n_mode = gsfe_pkg::MODE_RMC;
                end else begin
                    n_mode = gsfe_pkg::MODE_WAIT;
                end
            end
        end
    end

    // field capture
    always_comb begin
        n_emit      = 1'b0;
        n_cap.kind  = gsfe_pkg::KIND_TIME;
        n_cap.chars = '0;
        if (w_live) begin
            case (r_mode)
                gsfe_pkg::MODE_GGA: begin
                    if (w_pos_inc == gsfe_pkg::POS_TIME_LAST) begin
                        n_emit     = 1'b1;
                        n_cap.kind = gsfe_pkg::KIND_TIME;
                        for (int i = 0; i < 5; i++) begin
                            n_cap.chars[i] = r_time[i];
                        end
                        n_cap.chars[5] = i_rx_byte;
                    end else if (w_pos_inc == gsfe_pkg::POS_NS) begin
                        n_emit         = 1'b1;
                        n_cap.kind     = gsfe_pkg::KIND_NS;
                        n_cap.chars[0] = i_rx_byte;
                    end else if (w_pos_inc == gsfe_pkg::POS_EW) begin
                        n_emit         = 1'b1;
                        n_cap.kind     = gsfe_pkg::KIND_EW;
                        n_cap.chars[0] = i_rx_byte;
                    end else if (w_pos_inc == gsfe_pkg::POS_SAT_LAST) begin
                        n_emit         = 1'b1;
                        n_cap.kind     = gsfe_pkg::KIND_SAT;
                        n_cap.chars[0] = r_sat;
                        n_cap.chars[1] = i_rx_byte;
                    end
                end
                gsfe_pkg::MODE_RMC: begin
                    if (w_pos_inc == gsfe_pkg::POS_SPD_LAST) begin
                        n_emit     = 1'b1;
                        n_cap.kind = gsfe_pkg::KIND_SPEED;
                        for (int i = 0; i < 3; i++) begin
                            n_cap.chars[i] = r_spd[i];
                        end
                        n_cap.chars[3] = i_rx_byte;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_mode      <= gsfe_pkg::MODE_WAIT;
            r_cap_valid <= 1'b0;
        end else begin
            r_pos  <= n_pos;
            r_mode <= n_mode;
            if (i_en) begin
                r_cap_valid <= n_emit;
            end
        end
    end

    // character stores; each entry is written at an earlier byte of the same sentence than the one that reads it
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cap <= n_cap;
        end
        if (w_live && r_mode == gsfe_pkg::MODE_HEADER) begin
            for (int i = 0; i < 4; i++) begin
                if (w_pos_inc == 6'(i + 1)) begin
                    r_hdr[i] <= i_rx_byte;
                end
            end
        end
        if (w_live && r_mode == gsfe_pkg::MODE_GGA) begin
            for (int i = 0; i < 6; i++) begin
                if (w_pos_inc == gsfe_pkg::POS_TIME_FIRST + 6'(i)) begin
                    r_time[i] <= i_rx_byte;
                end
            end
            if (w_pos_inc == gsfe_pkg::POS_SAT_FIRST) begin
                r_sat <= i_rx_byte;
            end
        end
        if (w_live && r_mode == gsfe_pkg::MODE_RMC) begin
            for (int i = 0; i < 3; i++) begin
                if (w_pos_inc == gsfe_pkg::POS_SPD_FIRST + 6'(i)) begin
                    r_spd[i] <= i_rx_byte;
                end
            end
        end
    end

    assign o_cap_valid = r_cap_valid;
    assign o_cap       = r_cap;

    `ASSERT_NEXT(a_cap_needs_beat, i_clk, i_rst_n, i_en && !i_accept, !o_cap_valid, "capture without an accepted beat")
    `ASSERT_NEXT(a_no_cap_outside_body, i_clk, i_rst_n, i_en && (r_mode == gsfe_pkg::MODE_WAIT || r_mode == gsfe_pkg::MODE_HEADER), !o_cap_valid, "capture outside a GGA or RMC body")

endmodule

`default_nettype wire

@@ rtl/gsfe_decode.sv @@
`default_nettype none

`include "assert_macros.svh"

module gsfe_decode (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_cap_valid,
    input  wire gsfe_pkg::t_cap  i_cap,
    input  wire logic [4:0]      i_hour_offset,
    output logic                 o_dec_valid,
    output gsfe_pkg::t_dec       o_dec
);

    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    // Returns {scale, mantissa}; blanks, one sign, digits, optional single point.
    function automatic logic [15:0] dec_num(input logic [3:0][7:0] s,
                                            input logic [2:0] len,
                                            input logic allow_pt);
        logic        started;
        logic        done;
        logic        neg;
        logic        point;
        logic [13:0] m;
        logic [1:0]  sc;
        logic [7:0]  c;
        started = 1'b0;
        done    = 1'b0;
        neg     = 1'b0;
        point   = 1'b0;
        m       = '0;
        sc      = '0;
        for (int i = 0; i < 4; i++) begin
            c = s[i];
            if (3'(i) < len && !done) begin
                if (!started && is_blank(c)) begin
                    started = 1'b0;
                end else if (!started && (c == 8'h2B || c == 8'h2D)) begin
                    started = 1'b1;
                    neg     = (c == 8'h2D);
                end else begin
                    started = 1'b1;
                    if (c >= 8'h30 && c <= 8'h39) begin
                        m = 14'(m * 14'd10) + 14'(c - 8'h30);
                        if (point) begin
                            sc = sc + 2'd1;
                        end
                    end else if (allow_pt && c == 8'h2E && !point) begin
                        point = 1'b1;
                    end else begin
                        done = 1'b1;
                    end
                end
            end
        end
        return neg ? 16'd0 : {sc, m};
    endfunction

    logic [15:0]     w_lo;
    logic [15:0]     w_mid;
    logic [15:0]     w_hi;
    logic [15:0]     w_spd;
    logic [7:0]      w_hsum;
    gsfe_pkg::t_dec  n_dec;
    gsfe_pkg::t_dec  r_dec;
    logic            r_dec_valid;

    assign w_lo   = dec_num({16'h0, i_cap.chars[1:0]}, 3'd2, 1'b0);
    assign w_mid  = dec_num({16'h0, i_cap.chars[3:2]}, 3'd2, 1'b0);
    assign w_hi   = dec_num({16'h0, i_cap.chars[5:4]}, 3'd2, 1'b0);
    assign w_spd  = dec_num(i_cap.chars[3:0], 3'd4, 1'b1);
    assign w_hsum = 8'(w_lo[6:0]) + 8'(i_hour_offset);

    always_comb begin
        n_dec      = '0;
        n_dec.kind = i_cap.kind;
        case (i_cap.kind)
            gsfe_pkg::KIND_TIME: begin
                n_dec.hours   = w_hsum[7] ? 7'd127 : w_hsum[6:0];
                n_dec.minutes = w_mid[6:0];
                n_dec.seconds = w_hi[6:0];
            end
            gsfe_pkg::KIND_NS, gsfe_pkg::KIND_EW: begin
                n_dec.value = 15'(i_cap.chars[0]);
            end
            gsfe_pkg::KIND_SAT: begin
                n_dec.value = 15'(w_lo[6:0]);
            end
            gsfe_pkg::KIND_SPEED: begin
                n_dec.mant  = w_spd[13:0];
                n_dec.scale = w_spd[15:14];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dec_valid <= 1'b0;
        end else if (i_en) begin
            r_dec_valid <= i_cap_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dec <= n_dec;
        end
    end

    assign o_dec_valid = r_dec_valid;
    assign o_dec       = r_dec;

    `ASSERT_NEXT(a_dec_follows_cap, i_clk, i_rst_n, i_en && i_cap_valid, o_dec_valid, "decoded field lost")

endmodule

`default_nettype wire

@@ rtl/gps_sentence_field_extractor.sv @@
`default_nettype none

`include "assert_macros.svh"

// Extracts fields from an NMEA-style GPS byte stream, one byte per beat and a new byte
// every cycle while not stalled. '$' restarts a sentence; GPGGA gives time, N/S, E/W
// and satellite count, GPRMC gives speed in km/h (truncated). A field, once its last byte
// is taken, passes through the parser register, decode register, then the output register
// behind the speed multiplier (14 x 33 bits). The whole pipeline advances together,
// so the input takes a byte whenever the output register is empty or being taken.
// hour_offset resets to 1 and is added to the hour without wrapping (saturates at 127).
module gps_sentence_field_extractor (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_rx_valid,
    output logic              o_rx_ready,
    input  wire logic [7:0]   i_rx_byte,
    input  wire logic         i_cfg_we,
    input  wire logic [4:0]   i_cfg_data,
    output logic              o_res_valid,
    input  wire logic         i_res_ready,
    output logic [2:0]        o_field_kind,
    output logic [6:0]        o_hours,
    output logic [6:0]        o_minutes,
    output logic [6:0]        o_seconds,
    output logic [14:0]       o_value
);

    logic            w_en;
    logic            w_accept;
    logic [4:0]      r_hour_offset;
    logic            w_cap_valid;
    gsfe_pkg::t_cap  w_cap;
    logic            w_dec_valid;
    gsfe_pkg::t_dec  w_dec;
    logic [46:0]     w_prod;
    logic            r_out_valid;
    logic [2:0]      r_kind;
    logic [6:0]      r_hours;
    logic [6:0]      r_minutes;
    logic [6:0]      r_seconds;
    logic [14:0]     r_value;

    assign w_en     = !r_out_valid || i_res_ready;
    assign w_accept = i_rx_valid && w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hour_offset <= gsfe_pkg::HOUR_OFFSET_RST;
        end else if (i_cfg_we) begin
            r_hour_offset <= i_cfg_data;
        end
    end

    gsfe_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_accept    (w_accept),
        .i_rx_byte   (i_rx_byte),
        .o_cap_valid (w_cap_valid),
        .o_cap       (w_cap)
    );

    gsfe_decode u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_en),
        .i_cap_valid   (w_cap_valid),
        .i_cap         (w_cap),
        .i_hour_offset (r_hour_offset),
        .o_dec_valid   (w_dec_valid),
        .o_dec         (w_dec)
    );

    // knots to km/h by reciprocal multiply
    assign w_prod = 47'(w_dec.mant) * 47'(gsfe_pkg::SPEED_RECIP[w_dec.scale]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_dec_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_kind    <= w_dec.kind;
            r_hours   <= w_dec.hours;
            r_minutes <= w_dec.minutes;
            r_seconds <= w_dec.seconds;
            r_value   <= (w_dec.kind == gsfe_pkg::KIND_SPEED)
                         ? w_prod[gsfe_pkg::SPEED_SHIFT +: 15] : w_dec.value;
        end
    end

    assign o_rx_ready   = w_en;
    assign o_res_valid  = r_out_valid;
    assign o_field_kind = r_kind;
    assign o_hours      = r_hours;
    assign o_minutes    = r_minutes;
    assign o_seconds    = r_seconds;
    assign o_value      = r_value;

    `ASSERT_CLK(a_time_fields_only_for_time, i_clk, i_rst_n, o_res_valid && o_field_kind != gsfe_pkg::KIND_TIME |-> o_hours == 7'd0 && o_minutes == 7'd0 && o_seconds == 7'd0, "time fields set on a non-time result")

endmodule

`default_nettype wire

@@ verif/gps_sentence_field_extractor_tb.sv @@
`default_nettype none

module gps_sentence_field_extractor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STUCK_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RAND_BYTES   = 1000;
    localparam int PHASE_BYTES  = 250;
    localparam int KNOT_NUM     = 1852;
    localparam int KNOT_DEN     = 1000;

    typedef struct packed {
        gsfe_pkg::t_kind kind;
        logic [6:0]      hours;
        logic [6:0]      minutes;
        logic [6:0]      seconds;
        logic [14:0]     value;
    } t_gps_field;

    // One directed sentence. ofs < 0 keeps the current hour offset; bytes of
    // pre go out ahead of the dollar sign. fix, when on, replaces the
    // predicted result of the same kind.
    typedef struct packed {
        int          ofs;
        logic [39:0] hdr;
        logic [47:0] tm;
        logic [7:0]  ns;
        logic [7:0]  ew;
        logic [15:0] sat;
        logic [31:0] spd;
        int          len;
        int          pre_n;
        logic [63:0] pre;
        bit          fix_on;
        t_gps_field  fix;
    } t_gps_row;

    localparam t_gps_row DIR_ROWS [18] = '{
        '{-1, "GPGGA", "000000", "N", "E", "00", "0000", 50, 7, "GPGGA,1",
          1'b1, '{gsfe_pkg::KIND_TIME, 7'd1, 7'd0, 7'd0, 15'd0}},
        '{0, "GPGGA", "235959", "S", "W", "12", "0000", 48, 0, 64'h0,
          1'b1, '{gsfe_pkg::KIND_TIME, 7'd23, 7'd59, 7'd59, 15'd0}},
        '{31, "GPGGA", "999999", "N", "E", "07", "0000", 47, 0, 64'h0,
          1'b1, '{gsfe_pkg::KIND_TIME, 7'd127, 7'd99, 7'd99, 15'd0}},
        '{23, "GPGGA", " 1+2-3", "S", "E", "5 ", "0000", 50, 0, 64'h0,
          1'b1, '{gsfe_pkg::KIND_NS, 7'd0, 7'd0, 7'd0, 15'd83}},
        '{5, "GPGGA", {8'h09, "9ab12"}, "N", "W", "99", "0000", 46, 0, 64'h0,
          1'b1, '{gsfe_pkg::KIND_SAT, 7'd0, 7'd0, 7'd0, 15'd99}},
        '{16, "GPGGA", {8'h0D, 8'h0B, "1234"}, 8'h00, 8'hFF, "-5", "0000", 55, 0, 64'h0,
          1'b1, '{gsfe_pkg::KIND_SAT, 7'd0, 7'd0, 7'd0, 15'd0}},
        '{-1, "GPRMC", "000000", "N", "E", "00", "9999", 48, 0, 64'h0,
          1'b1, '{gsfe_pkg::KIND_SPEED, 7'd0, 7'd0, 7'd0, 15'd18518}},
        '{-1, "GPRMC", "000000", "N", "E", "00", "0000", 49, 0, 64'h0,
          1'b1, '{gsfe_pkg::KIND_SPEED, 7'd0, 7'd0, 7'd0, 15'd0}},
        '{-1, "GPRMC", "000000", "N", "E", "00", "12.5", 50, 0, 64'h0, 1'b0, '0},
        '{-1, "GPRMC", "000000", "N", "E", "00", ".999", 50, 0, 64'h0, 1'b0, '0},
        '{-1, "GPRMC", "000000", "N", "E", "00", "1.2.", 50, 0, 64'h0, 1'b0, '0},
        '{-1, "GPRMC", "000000", "N", "E", "00", " +7x", 50, 0, 64'h0, 1'b0, '0},
        '{-1, "GPRMC", "000000", "N", "E", "00", "-100", 50, 0, 64'h0,
          1'b1, '{gsfe_pkg::KIND_SPEED, 7'd0, 7'd0, 7'd0, 15'd0}},
        '{-1, "GPGSV", "101010", "N", "E", "11", "0000", 50, 0, 64'h0, 1'b0, '0},
        '{-1, "GPRMB", "101010", "N", "E", "11", "1234", 50, 0, 64'h0, 1'b0, '0},
        // a partial sentence cut short by the next dollar sign
        '{-1, "GPRMC", "000000", "N", "E", "00", "0042", 50, 8, "$GPGGA,1", 1'b0, '0},
        '{-1, "GPGGA", "083015", "S", "W", "08", "0000", 80, 0, 64'h0, 1'b0, '0},
        '{-1, "GPGGA", "120000", "N", "E", "00", "0000", 20, 0, 64'h0, 1'b0, '0}
    };

    logic        i_clk;
    logic        rst_n;
    logic        rx_valid;
    logic        o_rx_ready;
    logic [7:0]  rx_byte;
    logic        cfg_we;
    logic [4:0]  cfg_data;
    logic        o_res_valid;
    logic        res_ready;
    logic [2:0]  o_field_kind;
    logic [6:0]  o_hours;
    logic [6:0]  o_minutes;
    logic [6:0]  o_seconds;
    logic [14:0] o_value;

    // model state
    logic [5:0]      pos;
    gsfe_pkg::t_mode mode;
    logic [7:0]      hdr_c [4];
    logic [7:0]      tm_c [6];
    logic [7:0]      sat_c;
    logic [7:0]      spd_c [3];
    logic [4:0]      hr_ofs;

    t_gps_field  pending_fields [$];
    bit          fix_on;
    t_gps_field  fix;
    bit          calm_tx;
    int          n_bytes;
    int          n_fail;
    int          stuck_cycles;

    gps_sentence_field_extractor DUT (
        .i_clk        (i_clk),
        .i_rst_n      (rst_n),
        .i_rx_valid   (rx_valid),
        .o_rx_ready   (o_rx_ready),
        .i_rx_byte    (rx_byte),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .o_res_valid  (o_res_valid),
        .i_res_ready  (res_ready),
        .o_field_kind (o_field_kind),
        .o_hours      (o_hours),
        .o_minutes    (o_minutes),
        .o_seconds    (o_seconds),
        .o_value      (o_value)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit is_blank(input logic [7:0] c);
        return c == " " || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    // Blanks, then one sign, then digits (and one point for speed).
    function automatic int unsigned num_value(input logic [7:0] s [4], input int n,
                                              input bit with_point,
                                              output int unsigned scale);
        int          i;
        int unsigned acc;
        bit          neg;
        bit          seen_pt;
        bit          stop;
        i = 0;
        acc = 0;
        scale = 1;
        neg = 1'b0;
        seen_pt = 1'b0;
        stop = 1'b0;
        while (i < n && is_blank(s[i]))
            i++;
        if (i < n && (s[i] == "+" || s[i] == "-")) begin
            neg = (s[i] == "-");
            i++;
        end
        while (i < n && !stop) begin
            if (s[i] >= "0" && s[i] <= "9") begin
                acc = acc * 10 + (s[i] - "0");
                if (seen_pt)
                    scale = scale * 10;
                i++;
            end else if (with_point && s[i] == "." && !seen_pt) begin
                seen_pt = 1'b1;
                i++;
            end else begin
                stop = 1'b1;
            end
        end
        return neg ? 0 : acc;
    endfunction

    function automatic bit parse_gps_byte(input logic [7:0] b, output t_gps_field res);
        logic [7:0]  d [4];
        int unsigned sc;
        int unsigned hh;
        int unsigned mant;
        res = '0;
        if (b == gsfe_pkg::CH_DOLLAR) begin
            pos = '0;
            mode = gsfe_pkg::MODE_HEADER;
            return 1'b0;
        end
        if (mode == gsfe_pkg::MODE_WAIT)
            return 1'b0;
        if (pos < gsfe_pkg::POS_MAX)
            pos = pos + 1'b1;
        case (mode)
            gsfe_pkg::MODE_HEADER: begin
                if (pos < gsfe_pkg::POS_HDR_LAST) begin
                    hdr_c[pos - 1] = b;
                end else if (pos == gsfe_pkg::POS_HDR_LAST) begin
                    if ({hdr_c[0], hdr_c[1], hdr_c[2], hdr_c[3], b}
                        == gsfe_pkg::HDR_GGA)
                        mode = gsfe_pkg::MODE_GGA;
                    else if ({hdr_c[0], hdr_c[1], hdr_c[2], hdr_c[3], b}
                             == gsfe_pkg::HDR_RMC)
                        mode = gsfe_pkg::MODE_RMC;
                    else
                        mode = gsfe_pkg::MODE_WAIT;
                end
                return 1'b0;
            end
            gsfe_pkg::MODE_GGA: begin
                if (pos >= gsfe_pkg::POS_TIME_FIRST && pos <= gsfe_pkg::POS_TIME_LAST)
                    tm_c[pos - gsfe_pkg::POS_TIME_FIRST] = b;
                if (pos == gsfe_pkg::POS_TIME_LAST) begin
                    res.kind = gsfe_pkg::KIND_TIME;
                    d = '{tm_c[0], tm_c[1], 8'h30, 8'h30};
                    hh = num_value(d, 2, 1'b0, sc) + hr_ofs;
                    res.hours = (hh > 127) ? 7'd127 : 7'(hh);
                    d = '{tm_c[2], tm_c[3], 8'h30, 8'h30};
                    res.minutes = 7'(num_value(d, 2, 1'b0, sc));
                    d = '{tm_c[4], tm_c[5], 8'h30, 8'h30};
                    res.seconds = 7'(num_value(d, 2, 1'b0, sc));
                    return 1'b1;
                end
                if (pos == gsfe_pkg::POS_NS || pos == gsfe_pkg::POS_EW) begin
                    res.kind = (pos == gsfe_pkg::POS_NS) ? gsfe_pkg::KIND_NS
                                                         : gsfe_pkg::KIND_EW;
                    res.value = {7'd0, b};
                    return 1'b1;
                end
                if (pos == gsfe_pkg::POS_SAT_FIRST)
                    sat_c = b;
                if (pos == gsfe_pkg::POS_SAT_LAST) begin
                    res.kind = gsfe_pkg::KIND_SAT;
                    d = '{sat_c, b, 8'h30, 8'h30};
                    res.value = 15'(num_value(d, 2, 1'b0, sc));
                    return 1'b1;
                end
                return 1'b0;
            end
            default: begin
                if (pos >= gsfe_pkg::POS_SPD_FIRST && pos < gsfe_pkg::POS_SPD_LAST)
                    spd_c[pos - gsfe_pkg::POS_SPD_FIRST] = b;
                if (pos == gsfe_pkg::POS_SPD_LAST) begin
                    res.kind = gsfe_pkg::KIND_SPEED;
                    d = '{spd_c[0], spd_c[1], spd_c[2], b};
                    mant = num_value(d, 4, 1'b1, sc);
                    res.value = 15'((mant * KNOT_NUM) / (KNOT_DEN * sc));
                    return 1'b1;
                end
                return 1'b0;
            end
        endcase
    endfunction

    task automatic check_field(input string name, input logic [14:0] want,
                               input logic [14:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_fail++;
        end
    endtask

    always @(posedge i_clk) begin
        t_gps_field nxt;
        if ((rx_valid && o_rx_ready) || (o_res_valid && res_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (rst_n) begin
            if (o_res_valid && res_ready) begin
                if (pending_fields.size() == 0) begin
                    $error("result beat with nothing pending: kind %0d value %0d",
                           o_field_kind, o_value);
                    n_fail++;
                end else begin
                    nxt = pending_fields.pop_front();
                    check_field("field_kind", 15'(nxt.kind), 15'(o_field_kind));
                    check_field("hours", 15'(nxt.hours), 15'(o_hours));
                    check_field("minutes", 15'(nxt.minutes), 15'(o_minutes));
                    check_field("seconds", 15'(nxt.seconds), 15'(o_seconds));
                    check_field("value", nxt.value, o_value);
                end
            end
            if (rx_valid && o_rx_ready) begin
                if (parse_gps_byte(rx_byte, nxt)) begin
                    if (fix_on && nxt.kind == fix.kind)
                        nxt = fix;
                    pending_fields.push_back(nxt);
                end
            end
        end
    end

    initial begin : watchdog
        wait (stuck_cycles >= STUCK_LIMIT);
        $display("gps_sentence_field_extractor_tb failed");
        $finish;
    end

    initial begin : result_sink
        int stall;
        bit calm;
        calm = 1'b0;
        wait (rst_n);
        forever begin
            if ($urandom_range(0, 15) == 0)
                calm = !calm;
            stall = calm ? 0 : $urandom_range(0, 12);
            @(negedge i_clk);
            if (stall > 0) begin
                res_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            res_ready <= 1'b1;
            do @(posedge i_clk); while (!o_res_valid);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = calm_tx ? 0 : $urandom_range(0, 12);
        @(negedge i_clk);
        if (gap > 0) begin
            rx_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge i_clk); while (!o_rx_ready);
        n_bytes++;
    endtask

    task automatic set_hour_offset(input logic [4:0] v);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        hr_ofs = v;
    endtask

    // Bytes that end no field may still be in flight, hence the pause.
    task automatic finish_phase();
        @(negedge i_clk);
        rx_valid <= 1'b0;
        while (pending_fields.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [7:0] filler_char(input bit noisy);
        if (!noisy || $urandom_range(0, 3) == 0)
            return ",";
        return 8'("0" + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] num_char();
        case ($urandom_range(0, 15))
            0: return " ";
            1: return 8'(9 + $urandom_range(0, 4));
            2: return "+";
            3: return "-";
            4: return ".";
            5: return 8'($urandom_range(0, 255));
            default: return 8'("0" + $urandom_range(0, 9));
        endcase
    endfunction

    task automatic send_sentence(input logic [39:0] hdr, input logic [47:0] tm,
                                 input logic [7:0] ns, input logic [7:0] ew,
                                 input logic [15:0] sat, input logic [31:0] spd,
                                 input int len, input bit noisy);
        logic [7:0] c;
        send_byte(gsfe_pkg::CH_DOLLAR);
        for (int p = 1; p <= len; p++) begin
            if (p <= gsfe_pkg::POS_HDR_LAST)
                c = hdr[8 * (gsfe_pkg::POS_HDR_LAST - p) +: 8];
            else if (p >= gsfe_pkg::POS_TIME_FIRST && p <= gsfe_pkg::POS_TIME_LAST)
                c = tm[8 * (gsfe_pkg::POS_TIME_LAST - p) +: 8];
            else if (p == gsfe_pkg::POS_NS)
                c = ns;
            else if (p == gsfe_pkg::POS_EW)
                c = ew;
            else if (hdr == gsfe_pkg::HDR_RMC && p >= gsfe_pkg::POS_SPD_FIRST
                     && p <= gsfe_pkg::POS_SPD_LAST)
                c = spd[8 * (gsfe_pkg::POS_SPD_LAST - p) +: 8];
            else if (hdr != gsfe_pkg::HDR_RMC && p >= gsfe_pkg::POS_SAT_FIRST
                     && p <= gsfe_pkg::POS_SAT_LAST)
                c = sat[8 * (gsfe_pkg::POS_SAT_LAST - p) +: 8];
            else
                c = filler_char(noisy);
            send_byte(c);
        end
    endtask

    function automatic logic [7:0] indicator_char();
        case ($urandom_range(0, 4))
            0: return "N";
            1: return "S";
            2: return "E";
            3: return "W";
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_random_sentence();
        logic [39:0] hdr;
        logic [47:0] tm;
        logic [15:0] sat;
        logic [31:0] spd;
        int          sel;
        int          len;
        if ($urandom_range(0, 3) == 0)
            calm_tx = !calm_tx;
        sel = $urandom_range(0, 19);
        if (sel == 19) begin
            repeat ($urandom_range(1, 30)) send_byte(8'($urandom_range(0, 255)));
            return;
        end
        hdr = (sel < 10 || sel == 17) ? gsfe_pkg::HDR_GGA : gsfe_pkg::HDR_RMC;
        if (sel >= 16)
            hdr[8 * $urandom_range(0, 4) +: 8] = 8'($urandom_range(0, 255));
        for (int k = 0; k < 6; k++)
            tm[8 * k +: 8] = num_char();
        for (int k = 0; k < 2; k++)
            sat[8 * k +: 8] = num_char();
        for (int k = 0; k < 4; k++)
            spd[8 * k +: 8] = num_char();
        case ($urandom_range(0, 9))
            0: len = $urandom_range(1, 47);
            1: len = $urandom_range(64, 75);
            default: len = $urandom_range(48, 63);
        endcase
        send_sentence(hdr, tm, indicator_char(), indicator_char(), sat, spd, len, 1'b1);
    endtask

    initial begin : stimulus
        t_gps_row row;
        int       goal;
        int       phase_end;
        rst_n    = 1'b0;
        rx_valid = 1'b0;
        rx_byte  = '0;
        cfg_we   = 1'b0;
        cfg_data = '0;
        res_ready = 1'b0;
        pos   = '0;
        mode  = gsfe_pkg::MODE_WAIT;
        hdr_c = '{default: 8'h00};
        tm_c  = '{default: 8'h30};
        sat_c = 8'h30;
        spd_c = '{default: 8'h30};
        hr_ofs = gsfe_pkg::HOUR_OFFSET_RST;
        fix_on = 1'b0;
        fix = '0;
        calm_tx = 1'b0;
        n_bytes = 0;
        n_fail = 0;
        stuck_cycles = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;

        foreach (DIR_ROWS[i]) begin
            row = DIR_ROWS[i];
            if (row.ofs >= 0)
                set_hour_offset(row.ofs[4:0]);
            fix_on = row.fix_on;
            fix = row.fix;
            for (int k = 0; k < row.pre_n; k++)
                send_byte(row.pre[8 * (row.pre_n - 1 - k) +: 8]);
            send_sentence(row.hdr, row.tm, row.ns, row.ew, row.sat, row.spd, row.len, 1'b0);
            finish_phase();
        end
        fix_on = 1'b0;

        goal = n_bytes + RAND_BYTES;
        while (n_bytes < goal) begin
            set_hour_offset(5'($urandom_range(0, 31)));
            phase_end = n_bytes + PHASE_BYTES;
            while (n_bytes < phase_end)
                send_random_sentence();
            finish_phase();
        end

        if (n_fail == 0)
            $display("gps_sentence_field_extractor_tb passed");
        else
            $display("gps_sentence_field_extractor_tb failed");
        $finish;
    end

endmodule

`default_nettype wire
